### sv/evad_pkg.sv
`timescale 1ns / 1ps

package evad_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int HOLD_W   = 8;
  localparam int SUM_W    = 40;
  localparam int BIT_W    = 4;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HANGOVER = 8'd2;

  localparam logic [LEVEL_W-1:0] HIGH_THR_RST = 16'd5000;
  localparam logic [LEVEL_W-1:0] LOW_THR_RST  = 16'd2000;
  localparam logic [HOLD_W-1:0]  HANGOVER_RST = 8'd8;

  localparam logic [BIT_W-1:0] TOP_BIT = 4'd15;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_end;
  } in_item_t;

  typedef struct packed {
    logic               speech;
    logic [LEVEL_W-1:0] level;
    logic               active;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             acc;
    logic             rms_clr;
    logic             sq;
    logic             mul;
    logic             cmp;
    logic             fin;
    logic [BIT_W-1:0] bit_idx;
  } dp_cmd_t;

endpackage

### sv/evad_ctrl.sv
`timescale 1ns / 1ps

module evad_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_frame_end,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output evad_pkg::dp_cmd_t cmd
);
  import evad_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_MUL,
    S_CMP,
    S_FIN
  } state_t;

  state_t           state_r;
  logic [BIT_W-1:0] bit_r;
  logic             out_valid_r;
  logic             in_acc;
  logic             out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd         = '0;
    cmd.bit_idx = bit_r;
    case (state_r)
      S_IDLE: begin
        cmd.acc     = in_acc;
        cmd.rms_clr = in_acc && in_frame_end;
      end
      S_SQ:  cmd.sq  = 1'b1;
      S_MUL: cmd.mul = 1'b1;
      S_CMP: cmd.cmp = 1'b1;
      S_FIN: cmd.fin = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bit_r       <= TOP_BIT;
      out_valid_r <= 1'b0;
    end else begin
      // hold the verdict until the output register is free
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_frame_end) begin
            bit_r   <= TOP_BIT;
            state_r <= S_SQ;
          end
        end
        S_SQ:  state_r <= S_MUL;
        S_MUL: state_r <= S_CMP;
        S_CMP: begin
          if (bit_r == '0) begin
            state_r <= S_FIN;
          end else begin
            bit_r   <= bit_r - 1'b1;
            state_r <= S_SQ;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/evad_dp.sv
`timescale 1ns / 1ps

module evad_dp #(
  parameter int FRAME_MAX = 512,
  parameter int CNT_W     = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  evad_pkg::dp_cmd_t                   cmd,
  input  evad_pkg::in_item_t                  in_data,
  input  logic                                cfg_we,
  input  logic [evad_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [evad_pkg::CFG_DATA_W-1:0]     cfg_data,
  output evad_pkg::out_item_t                 out_data
);
  import evad_pkg::*;

  localparam int ODD_W  = LEVEL_W + 1;
  localparam int SQ_W   = 2 * ODD_W;
  localparam int PROD_W = SQ_W + CNT_W;
  localparam int RHS_W  = SUM_W + 2;
  localparam int CMP_W  = (PROD_W > RHS_W) ? PROD_W : RHS_W;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(FRAME_MAX);

  logic [LEVEL_W-1:0] hi_thr_r, hi_thr_nxt;
  logic [LEVEL_W-1:0] lo_thr_r, lo_thr_nxt;
  logic [HOLD_W-1:0]  hang_r, hang_nxt;

  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [HOLD_W-1:0]  hold_r, hold_nxt;
  logic               voice_r, voice_nxt;

  logic [LEVEL_W-1:0] root_r, root_nxt;
  logic [SQ_W-1:0]    sq_r, sq_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  out_item_t          out_r, out_nxt;

  logic [SAMPLE_W-1:0]   mag;
  logic [2*SAMPLE_W-1:0] mag_sq;
  logic [SUM_W:0]        sum_add;
  logic [LEVEL_W-1:0]    cand;
  logic [ODD_W-1:0]      odd;
  logic                  fits;
  logic                  hi_hit;
  logic                  lo_hit;
  logic [HOLD_W-1:0]     hold_dec;

  // -32768 wraps to 0x8000, which read unsigned is its magnitude
  assign mag     = in_data.sample[SAMPLE_W-1] ? SAMPLE_W'(-in_data.sample)
                                              : SAMPLE_W'(in_data.sample);
  assign mag_sq  = mag * mag;
  assign sum_add = {1'b0, sum_r} + (SUM_W + 1)'(mag_sq);

  assign cand = root_r | (LEVEL_W'(1) << cmd.bit_idx);
  assign odd  = {cand, 1'b0} - ODD_W'(1);
  assign fits = CMP_W'(prod_r) <= CMP_W'({sum_r, 2'b00});

  assign hi_hit   = root_r >= hi_thr_r;
  assign lo_hit   = voice_r && (root_r >= lo_thr_r);
  assign hold_dec = hold_r - 1'b1;

  always_comb begin
    hi_thr_nxt = hi_thr_r;
    lo_thr_nxt = lo_thr_r;
    hang_nxt   = hang_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_HIGH_THR: hi_thr_nxt = cfg_data;
        REG_LOW_THR:  lo_thr_nxt = cfg_data;
        REG_HANGOVER: hang_nxt   = cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    hold_nxt  = hold_r;
    voice_nxt = voice_r;
    root_nxt  = root_r;
    sq_nxt    = sq_r;
    prod_nxt  = prod_r;
    out_nxt   = out_r;

    // drop samples past the frame limit, saturate the sum
    if (cmd.acc && (cnt_r < CNT_LIMIT)) begin
      sum_nxt = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.rms_clr) begin
      root_nxt = '0;
    end
    if (cmd.sq) begin
      sq_nxt = odd * odd;
    end
    if (cmd.mul) begin
      prod_nxt = sq_r * cnt_r;
    end
    if (cmd.cmp && fits) begin
      root_nxt = cand;
    end

    if (cmd.fin) begin
      out_nxt.level = root_r;
      if (hi_hit) begin
        voice_nxt      = 1'b1;
        hold_nxt       = hang_r;
        out_nxt.speech = 1'b1;
      end else if (lo_hit) begin
        hold_nxt       = hang_r;
        out_nxt.speech = 1'b1;
      end else if (hold_r != '0) begin
        hold_nxt       = hold_dec;
        out_nxt.speech = (hold_dec != '0);
        if (hold_dec == '0) begin
          voice_nxt = 1'b0;
        end
      end else begin
        out_nxt.speech = 1'b0;
        voice_nxt      = 1'b0;
      end
      out_nxt.active = voice_nxt;
      sum_nxt        = '0;
      cnt_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_thr_r <= HIGH_THR_RST;
      lo_thr_r <= LOW_THR_RST;
      hang_r   <= HANGOVER_RST;
      sum_r    <= '0;
      cnt_r    <= '0;
      hold_r   <= '0;
      voice_r  <= 1'b0;
    end else begin
      hi_thr_r <= hi_thr_nxt;
      lo_thr_r <= lo_thr_nxt;
      hang_r   <= hang_nxt;
      sum_r    <= sum_nxt;
      cnt_r    <= cnt_nxt;
      hold_r   <= hold_nxt;
      voice_r  <= voice_nxt;
    end
  end

  always_ff @(posedge clk) begin
    root_r <= root_nxt;
    sq_r   <= sq_nxt;
    prod_r <= prod_nxt;
    out_r  <= out_nxt;
  end

  assign out_data = out_r;

endmodule

### sv/energy_voice_activity_detector_core.sv
`timescale 1ns / 1ps

// Energy voice activity detector. Each accepted item is one signed 16-bit
// sample; frame_end marks the last sample of a frame. A sample without the
// mark adds its square to the sum. A marked sample closes the frame: the
// rounded RMS level is found bit by bit over sixteen bits (square the odd
// candidate, scale it by the sample count, compare with four times the sum
// of squares), then a final step applies the start/keep/hangover rules; no
// item is taken until that is done, nor while the previous result item
// still waits on the output. One result item is produced per frame. At most
// FRAME_MAX samples of a frame are accumulated; later ones still count
// towards closing it. The user must write thresholds and hangover length
// through the cfg port while the block is idle; the block does not enforce it.
module energy_voice_activity_detector_core #(
  parameter int FRAME_MAX = 512
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  evad_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output evad_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [evad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [evad_pkg::CFG_DATA_W-1:0] cfg_data
);
  import evad_pkg::*;

  localparam int CNT_W = $clog2(FRAME_MAX + 1);

  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  evad_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_frame_end (in_data.frame_end),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd)
  );

  evad_dp #(
    .FRAME_MAX (FRAME_MAX),
    .CNT_W     (CNT_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // a verdict only appears after a level search, never straight from an item
  a_out_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised while input side was open");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.level <= 16'd32768))
    else $error("level beyond full scale");

  a_active_needs_speech: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.speech) |-> !out_data.active)
    else $error("active flag set on a frame judged silent");
`endif

endmodule
